// ===== design/fecf_pkg.sv =====
// ----------------------------------------------------------------------------
// fecf_pkg
// Shared types, constants and control program of the erase command framer.
// ----------------------------------------------------------------------------
package fecf_pkg;

    localparam int unsigned MAX_ERASE_UNITS = 16;
    localparam int unsigned DIV_BITS        = 32;
    localparam int unsigned DIV_CNT_W       = $clog2(DIV_BITS + 1);
    localparam int unsigned STEP_W          = 4;

    localparam logic [7:0]  CMD_STANDARD      = 8'h43;
    localparam logic [7:0]  CMD_EXTENDED      = 8'h44;
    localparam logic [7:0]  ROM_GUARD_VERSION = 8'h91;
    localparam logic [16:0] NO_GUARD_UNIT     = 17'd65536;
    localparam logic [31:0] EXT_UNIT_LIMIT    = 32'h0000_FFFF;
    localparam logic [31:0] STD_UNIT_LIMIT    = 32'd256;

    typedef enum logic [2:0] {
        CFG_BASE_ADDR    = 3'd0,
        CFG_BYTE_SIZE    = 3'd1,
        CFG_UNIT_BYTES   = 3'd2,
        CFG_UNIT_TOTAL   = 3'd3,
        CFG_EXT_MODE     = 3'd4,
        CFG_ROM_VERSION  = 3'd5,
        CFG_BANK2_UNIT   = 3'd6,
        CFG_GUARD_DELAY  = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_INVALID     = 2'd1,
        ST_RANGE       = 2'd2,
        ST_UNSUPPORTED = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0] flash_base_address;
        logic [31:0] flash_byte_size;
        logic [31:0] erase_unit_bytes;
        logic [16:0] erase_unit_total;
        logic        extended_mode;
        logic [7:0]  rom_version;
        logic [16:0] second_bank_first_unit;
        logic [15:0] guard_delay_ms;
    } cfg_t;

    typedef struct packed {
        logic [31:0] start_address;
        logic [31:0] byte_count;
    } in_item_t;

    typedef struct packed {
        logic [7:0] wire_byte;
        logic       frame_part;
        status_t    status;
        logic       guard_wait;
        logic       last;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_TAKE        = 3'd0,
        OP_CHECK_ARGS  = 3'd1,
        OP_DIV_FIRST   = 3'd2,
        OP_WAIT_FIRST  = 3'd3,
        OP_DIV_LAST    = 3'd4,
        OP_WAIT_LAST   = 3'd5,
        OP_CHECK_UNITS = 3'd6,
        OP_EMIT        = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        SEL_CMD     = 3'd0,
        SEL_NCMD    = 3'd1,
        SEL_CNT_HI  = 3'd2,
        SEL_CNT_LO  = 3'd3,
        SEL_UNIT_HI = 3'd4,
        SEL_UNIT_LO = 3'd5,
        SEL_XSUM    = 3'd6,
        SEL_STATUS  = 3'd7
    } sel_t;

    typedef enum logic [1:0] {
        COND_NONE   = 2'd0,
        COND_FAIL   = 2'd1,
        COND_MORE   = 2'd2,
        COND_ALWAYS = 2'd3
    } cond_t;

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        op_t   op;
        sel_t  sel;
        logic  part;
        logic  last;
        logic  ext_only;
        cond_t cond;
        step_t target;
    } ucode_word_t;

    typedef struct packed {
        logic hold;
        logic fail;
        logic more;
    } seq_status_t;

    localparam step_t STEP_TAKE = 4'd0;
    localparam step_t STEP_UNIT = 4'd11;
    localparam step_t STEP_FAIL = 4'd14;

    function automatic ucode_word_t uw(op_t op, sel_t sel, logic part, logic last,
                                       logic ext_only, cond_t cond, step_t target);
        ucode_word_t w;
        w.op       = op;
        w.sel      = sel;
        w.part     = part;
        w.last     = last;
        w.ext_only = ext_only;
        w.cond     = cond;
        w.target   = target;
        return w;
    endfunction

    function automatic ucode_word_t ucode(step_t step);
        ucode_word_t w;
        unique case (step)
            4'd0:  w = uw(OP_TAKE,        SEL_CMD,     1'b0, 1'b0, 1'b0, COND_NONE,   STEP_TAKE);
            4'd1:  w = uw(OP_CHECK_ARGS,  SEL_CMD,     1'b0, 1'b0, 1'b0, COND_FAIL,   STEP_FAIL);
            4'd2:  w = uw(OP_DIV_FIRST,   SEL_CMD,     1'b0, 1'b0, 1'b0, COND_NONE,   STEP_TAKE);
            4'd3:  w = uw(OP_WAIT_FIRST,  SEL_CMD,     1'b0, 1'b0, 1'b0, COND_NONE,   STEP_TAKE);
            4'd4:  w = uw(OP_DIV_LAST,    SEL_CMD,     1'b0, 1'b0, 1'b0, COND_NONE,   STEP_TAKE);
            4'd5:  w = uw(OP_WAIT_LAST,   SEL_CMD,     1'b0, 1'b0, 1'b0, COND_NONE,   STEP_TAKE);
            4'd6:  w = uw(OP_CHECK_UNITS, SEL_CMD,     1'b0, 1'b0, 1'b0, COND_FAIL,   STEP_FAIL);
            4'd7:  w = uw(OP_EMIT,        SEL_CMD,     1'b0, 1'b0, 1'b0, COND_NONE,   STEP_TAKE);
            4'd8:  w = uw(OP_EMIT,        SEL_NCMD,    1'b0, 1'b0, 1'b0, COND_NONE,   STEP_TAKE);
            4'd9:  w = uw(OP_EMIT,        SEL_CNT_HI,  1'b1, 1'b0, 1'b1, COND_NONE,   STEP_TAKE);
            4'd10: w = uw(OP_EMIT,        SEL_CNT_LO,  1'b1, 1'b0, 1'b0, COND_NONE,   STEP_TAKE);
            4'd11: w = uw(OP_EMIT,        SEL_UNIT_HI, 1'b1, 1'b0, 1'b1, COND_NONE,   STEP_TAKE);
            4'd12: w = uw(OP_EMIT,        SEL_UNIT_LO, 1'b1, 1'b0, 1'b0, COND_MORE,   STEP_UNIT);
            4'd13: w = uw(OP_EMIT,        SEL_XSUM,    1'b1, 1'b1, 1'b0, COND_ALWAYS, STEP_TAKE);
            4'd14: w = uw(OP_EMIT,        SEL_STATUS,  1'b0, 1'b1, 1'b0, COND_ALWAYS, STEP_TAKE);
            default: w = uw(OP_WAIT_FIRST, SEL_CMD,    1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_TAKE);
        endcase
        return w;
    endfunction

endpackage

// ===== design/fecf_divider.sv =====
// ----------------------------------------------------------------------------
// fecf_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fecf_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] quotient
);
    import fecf_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]          quo_reg, quo_next;
    logic [31:0]          rem_reg, rem_next;
    logic [31:0]          div_reg, div_next;
    logic [32:0]          rem_shift;
    logic [32:0]          rem_trial;

    always_comb begin
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        rem_shift = {rem_reg, quo_reg[31]};
        rem_trial = rem_shift - {1'b0, div_reg};
        if (start) begin
            cnt_next = DIV_CNT_W'(DIV_BITS);
            quo_next = dividend;
            rem_next = '0;
            div_next = divisor;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            if (!rem_trial[32]) begin
                rem_next = rem_trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = rem_shift[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

// ===== design/fecf_datapath.sv =====
// ----------------------------------------------------------------------------
// fecf_datapath
// Request registers, range checks, unit counter, checksum and result register,
// driven by one control word per step.
// ----------------------------------------------------------------------------
module fecf_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fecf_pkg::ucode_word_t ctrl,
    input  fecf_pkg::cfg_t        cfg,
    input  logic                  s_valid,
    input  fecf_pkg::in_item_t    s_data,
    input  logic                  m_ready,
    output logic                  m_valid,
    output fecf_pkg::out_item_t   m_data,
    output fecf_pkg::seq_status_t seq_status
);
    import fecf_pkg::*;

    logic [31:0] addr_reg, size_reg;
    logic [31:0] first_reg, first_next;
    logic [31:0] lastu_reg, lastu_next;
    logic [15:0] unit_reg, unit_next;
    logic [7:0]  xsum_reg, xsum_next;
    status_t     status_reg, status_next;
    logic        guard_reg, guard_next;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_data_reg, m_data_next;

    logic [32:0] end_addr;
    logic [32:0] span;
    logic        range_bad;
    status_t     args_status;
    logic [31:0] unit_diff;
    logic        guard_hit;
    status_t     units_status;
    status_t     check_status;

    logic        div_start;
    logic        div_busy;
    logic [31:0] div_dividend;
    logic [31:0] div_quotient;

    logic        emit_active;
    logic        out_free;
    logic [7:0]  cmd_byte;
    logic [7:0]  emit_byte;

    fecf_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cfg.erase_unit_bytes),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    always_comb begin
        end_addr  = {1'b0, cfg.flash_base_address} + {1'b0, cfg.flash_byte_size};
        span      = end_addr - {1'b0, addr_reg};
        range_bad = (addr_reg < cfg.flash_base_address) || ({1'b0, addr_reg} >= end_addr) ||
                    ({1'b0, size_reg} > span);
        priority if (size_reg == '0) begin
            args_status = ST_INVALID;
        end else if (range_bad) begin
            args_status = ST_RANGE;
        end else if (cfg.erase_unit_bytes == '0) begin
            args_status = ST_INVALID;
        end else begin
            args_status = ST_OK;
        end

        unit_diff = lastu_reg - first_reg;
        guard_hit = (cfg.rom_version == ROM_GUARD_VERSION) &&
                    (cfg.second_bank_first_unit != NO_GUARD_UNIT) &&
                    (lastu_reg >= {15'b0, cfg.second_bank_first_unit});
        priority if ((lastu_reg >= {15'b0, cfg.erase_unit_total}) ||
                     (unit_diff >= 32'(MAX_ERASE_UNITS))) begin
            units_status = ST_RANGE;
        end else if (guard_hit && (cfg.guard_delay_ms == '0)) begin
            units_status = ST_UNSUPPORTED;
        end else if (!cfg.extended_mode && (lastu_reg >= STD_UNIT_LIMIT)) begin
            units_status = ST_UNSUPPORTED;
        end else if (cfg.extended_mode && (lastu_reg > EXT_UNIT_LIMIT)) begin
            units_status = ST_UNSUPPORTED;
        end else begin
            units_status = ST_OK;
        end

        check_status = (ctrl.op == OP_CHECK_ARGS) ? args_status : units_status;
    end

    always_comb begin
        div_start    = (ctrl.op == OP_DIV_FIRST) || (ctrl.op == OP_DIV_LAST);
        div_dividend = (ctrl.op == OP_DIV_LAST)
                     ? (addr_reg - cfg.flash_base_address + size_reg - 32'd1)
                     : (addr_reg - cfg.flash_base_address);

        cmd_byte = cfg.extended_mode ? CMD_EXTENDED : CMD_STANDARD;
        unique case (ctrl.sel)
            SEL_CMD:     emit_byte = cmd_byte;
            SEL_NCMD:    emit_byte = ~cmd_byte;
            SEL_CNT_HI:  emit_byte = unit_diff[15:8];
            SEL_CNT_LO:  emit_byte = unit_diff[7:0];
            SEL_UNIT_HI: emit_byte = unit_reg[15:8];
            SEL_UNIT_LO: emit_byte = unit_reg[7:0];
            SEL_XSUM:    emit_byte = xsum_reg;
            SEL_STATUS:  emit_byte = 8'h00;
            default:     emit_byte = 8'h00;
        endcase

        out_free    = !m_valid_reg || m_ready;
        emit_active = (ctrl.op == OP_EMIT) && !(ctrl.ext_only && !cfg.extended_mode);
    end

    always_comb begin
        first_next   = first_reg;
        lastu_next   = lastu_reg;
        unit_next    = unit_reg;
        xsum_next    = xsum_reg;
        status_next  = status_reg;
        guard_next   = guard_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        unique case (ctrl.op)
            OP_TAKE: begin
                xsum_next   = '0;
                status_next = ST_OK;
                guard_next  = 1'b0;
            end
            OP_CHECK_ARGS: begin
                status_next = check_status;
            end
            OP_WAIT_FIRST: begin
                if (!div_busy) begin
                    first_next = div_quotient;
                end
            end
            OP_WAIT_LAST: begin
                if (!div_busy) begin
                    lastu_next = div_quotient;
                end
            end
            OP_CHECK_UNITS: begin
                status_next = check_status;
                guard_next  = guard_hit;
                unit_next   = first_reg[15:0];
            end
            OP_EMIT: begin
                if (emit_active && out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.wire_byte  = emit_byte;
                    m_data_next.frame_part = ctrl.part;
                    m_data_next.last       = ctrl.last;
                    if (ctrl.sel == SEL_STATUS) begin
                        m_data_next.status     = status_reg;
                        m_data_next.guard_wait = 1'b0;
                    end else begin
                        m_data_next.status     = ST_OK;
                        m_data_next.guard_wait = guard_reg;
                    end
                    if (ctrl.part && (ctrl.sel != SEL_XSUM)) begin
                        xsum_next = xsum_reg ^ emit_byte;
                    end
                    if (ctrl.sel == SEL_UNIT_LO) begin
                        unit_next = unit_reg + 16'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if ((ctrl.op == OP_TAKE) && s_valid) begin
            addr_reg <= s_data.start_address;
            size_reg <= s_data.byte_count;
        end
        first_reg  <= first_next;
        lastu_reg  <= lastu_next;
        unit_reg   <= unit_next;
        xsum_reg   <= xsum_next;
        status_reg <= status_next;
        guard_reg  <= guard_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        seq_status.hold = ((ctrl.op == OP_TAKE) && !s_valid) ||
                          (((ctrl.op == OP_WAIT_FIRST) || (ctrl.op == OP_WAIT_LAST)) && div_busy) ||
                          (emit_active && !out_free);
        seq_status.fail = (check_status != ST_OK);
        seq_status.more = (unit_reg != lastu_reg[15:0]);
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_fail_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg.status != ST_OK) |->
            m_data_reg.last && (m_data_reg.wire_byte == 8'h00) && !m_data_reg.guard_wait)
        else $error("status-only result malformed");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_div_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> div_busy)
        else $error("divider did not start");

    a_no_emit_in_check: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(ctrl.op == OP_EMIT))
        else $error("result loaded outside an emit step");

endmodule

// ===== design/fecf_sequencer.sv =====
// ----------------------------------------------------------------------------
// fecf_sequencer
// Step counter over the control program, with hold and conditional jumps.
// ----------------------------------------------------------------------------
module fecf_sequencer (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fecf_pkg::seq_status_t seq_status,
    output fecf_pkg::ucode_word_t ctrl,
    output logic                  s_ready
);
    import fecf_pkg::*;

    step_t       step_reg, step_next;
    ucode_word_t cw;
    logic        jump;

    always_comb begin
        cw   = ucode(step_reg);
        jump = (cw.cond == COND_ALWAYS) ||
               ((cw.cond == COND_FAIL) && seq_status.fail) ||
               ((cw.cond == COND_MORE) && seq_status.more);
        priority if (seq_status.hold) begin
            step_next = step_reg;
        end else if (jump) begin
            step_next = cw.target;
        end else begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_TAKE;
        end else begin
            step_reg <= step_next;
        end
    end

    assign ctrl    = cw;
    assign s_ready = (cw.op == OP_TAKE);

endmodule

// ===== design/flash_erase_command_framer.sv =====
// ----------------------------------------------------------------------------
// flash_erase_command_framer
// Maps an erase request onto erase units and frames the bootloader erase
// command and payload, one link byte per result transaction.
//
//   channel  signals                        direction  carries
//   s_       s_valid/s_ready/s_data         in         start address, byte count
//   m_       m_valid/m_ready/m_data         out        one link byte or a status
//   cfg_     cfg_wr_en/cfg_index/cfg_wr_data in        register write, no wait
//
// The first result follows the argument check, two unit divisions in the
// one-bit-per-cycle divider, the unit check and the first emit. Then one link
// byte a cycle in extended mode while m_ready is high (5 + 2N bytes for N
// units); standard mode gives 4 + N bytes. Failures: status only, from the
// argument or unit check. Reset is synchronous, active low, and restores the
// register defaults. A stalled result holds the sequencer at its emit step.
// ----------------------------------------------------------------------------
module flash_erase_command_framer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  fecf_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output fecf_pkg::out_item_t  m_data,
    input  logic                 cfg_wr_en,
    input  fecf_pkg::cfg_index_t cfg_index,
    input  logic [31:0]          cfg_wr_data
);
    import fecf_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    ucode_word_t ctrl;
    seq_status_t seq_status;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BASE_ADDR:   cfg_next.flash_base_address     = cfg_wr_data;
                CFG_BYTE_SIZE:   cfg_next.flash_byte_size        = cfg_wr_data;
                CFG_UNIT_BYTES:  cfg_next.erase_unit_bytes       = cfg_wr_data;
                CFG_UNIT_TOTAL:  cfg_next.erase_unit_total       = cfg_wr_data[16:0];
                CFG_EXT_MODE:    cfg_next.extended_mode          = cfg_wr_data[0];
                CFG_ROM_VERSION: cfg_next.rom_version            = cfg_wr_data[7:0];
                CFG_BANK2_UNIT:  cfg_next.second_bank_first_unit = cfg_wr_data[16:0];
                CFG_GUARD_DELAY: cfg_next.guard_delay_ms         = cfg_wr_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flash_base_address     <= 32'h0800_0000;
            cfg_reg.flash_byte_size        <= 32'h0020_0000;
            cfg_reg.erase_unit_bytes       <= 32'h0002_0000;
            cfg_reg.erase_unit_total       <= 17'd16;
            cfg_reg.extended_mode          <= 1'b1;
            cfg_reg.rom_version            <= 8'h00;
            cfg_reg.second_bank_first_unit <= NO_GUARD_UNIT;
            cfg_reg.guard_delay_ms         <= 16'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    fecf_sequencer u_sequencer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .seq_status (seq_status),
        .ctrl       (ctrl),
        .s_ready    (s_ready)
    );

    fecf_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_data     (s_data),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_data     (m_data),
        .seq_status (seq_status)
    );

endmodule
